>>> src/tilt_pkg.sv
package tilt_pkg;

    // sample and arithmetic sizes
    localparam int SAMPLE_BITS   = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int N_CRD         = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int IDX_W         = 5;

    localparam int SQRT_FRAC = 16;
    localparam int VEC_FRAC  = 24;
    localparam int DEG_FRAC  = 16;
    localparam int OUT_SHIFT = 9;

    localparam int SQ_W  = 2 * SAMPLE_BITS;          // x*x + y*y
    localparam int V_W   = SQ_W + 2 * SQRT_FRAC;     // radicand
    localparam int R_W   = V_W / 2;                  // root bits, one per sqrt cell
    localparam int REM_W = R_W + 1;                  // partial remainder
    localparam int VEC_W = SAMPLE_BITS + VEC_FRAC + 3;
    localparam int ACC_W = 26;
    localparam int ANGLE_W = 15;

    localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(90 * (1 << DEG_FRAC));
    localparam logic signed [ACC_W-1:0] HALF_TURN    = ACC_W'(180 * (1 << DEG_FRAC));
    localparam logic signed [ACC_W-1:0] ROUND_HALF   = ACC_W'(1 << (OUT_SHIFT - 1));

    // one square-root cell word
    typedef struct packed {
        logic [REM_W-1:0]             rem;
        logic [R_W-1:0]               root;
        logic [V_W-1:0]               v;
        logic                         zero;
        logic signed [SAMPLE_BITS-1:0] z;
    } t_sq;

    // one rotation cell word
    typedef struct packed {
        logic                    zero;
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [ACC_W-1:0] acc;
    } t_crd;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic signed [ACC_W-1:0] atan_tab(input logic [IDX_W-1:0] idx);
        logic signed [ACC_W-1:0] a;
        case (idx)
            5'd0:    a = ACC_W'(2949120);
            5'd1:    a = ACC_W'(1740967);
            5'd2:    a = ACC_W'(919879);
            5'd3:    a = ACC_W'(466945);
            5'd4:    a = ACC_W'(234379);
            5'd5:    a = ACC_W'(117304);
            5'd6:    a = ACC_W'(58666);
            5'd7:    a = ACC_W'(29335);
            5'd8:    a = ACC_W'(14668);
            5'd9:    a = ACC_W'(7334);
            5'd10:   a = ACC_W'(3667);
            5'd11:   a = ACC_W'(1833);
            5'd12:   a = ACC_W'(917);
            5'd13:   a = ACC_W'(458);
            5'd14:   a = ACC_W'(229);
            5'd15:   a = ACC_W'(115);
            5'd16:   a = ACC_W'(57);
            5'd17:   a = ACC_W'(29);
            5'd18:   a = ACC_W'(14);
            5'd19:   a = ACC_W'(7);
            5'd20:   a = ACC_W'(4);
            5'd21:   a = ACC_W'(2);
            5'd22:   a = ACC_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> src/tilt_if.sv
interface tilt_in_if import tilt_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface tilt_out_if import tilt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] incl_angle;
    logic               zero_vector;

    modport source (output valid, output incl_angle, output zero_vector, input ready);
    modport sink   (input valid, input incl_angle, input zero_vector, output ready);
endinterface

>>> src/tilt_sqrt_cell.sv
module tilt_sqrt_cell import tilt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_sq  i_d,
    output logic o_valid,
    output t_sq  o_d
);

    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             fit;
    logic             r_valid;
    t_sq              r_d;

    // one root bit: bring down two radicand bits, try 4*root + 1
    assign cur   = {i_d.rem, i_d.v[V_W-1 -: 2]};
    assign trial = {1'b0, i_d.root, 2'b01};
    assign fit   = (cur >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_d.rem  <= fit ? REM_W'(cur - trial) : cur[REM_W-1:0];
            r_d.root <= {i_d.root[R_W-2:0], fit};
            r_d.v    <= {i_d.v[V_W-3:0], 2'b00};
            r_d.zero <= i_d.zero;
            r_d.z    <= i_d.z;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

>>> src/tilt_cordic_cell.sv
module tilt_cordic_cell import tilt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_idx,
    input  logic             i_valid,
    input  t_crd             i_d,
    output logic             o_valid,
    output t_crd             o_d
);

    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic signed [ACC_W-1:0] ang;
    logic                    r_valid;
    t_crd                    r_d;

    assign vx  = i_d.vx;
    assign vy  = i_d.vy;
    assign dx  = vy >>> i_idx;
    assign dy  = vx >>> i_idx;
    assign ang = atan_tab(i_idx);

    // vectoring: drive vy toward zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_d.zero <= i_d.zero;
            if (!vy[VEC_W-1]) begin
                r_d.vx  <= vx + dx;
                r_d.vy  <= vy - dy;
                r_d.acc <= i_d.acc + ang;
            end else begin
                r_d.vx  <= vx - dx;
                r_d.vy  <= vy + dy;
                r_d.acc <= i_d.acc - ang;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

>>> src/accel_tilt_angle_top.sv
// tilt of a three-axis accelerometer sample away from +z, in 1/128 degree
//
// input channel i_smp: one word per sample, signed accel_x, accel_y, accel_z
// output channel o_res: one word per sample, incl_angle (0..23040) and
// zero_vector, set with angle 0 when all three axes read zero
// both channels move a word on a clock edge with valid and ready high
//
// datapath: squares, sum, a chain of R_W square-root cells (one root bit each),
// a quadrant fold for negative z, then a chain of N_CRD cordic vectoring cells
// throughput: one word per cycle while o_res.ready stays high
//
// the output register is backed by a one-word skid register; the chain only
// stalls once the skid register is full, and i_smp.ready is low exactly then
// reset (synchronous, active low) empties the chain and both output registers
module accel_tilt_angle_top import tilt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tilt_in_if.sink           i_smp,
    tilt_out_if.source        o_res
);

    logic en;

    // sign-extended samples, wide enough for their squares
    logic signed [SQ_W-1:0]        x_w;
    logic signed [SQ_W-1:0]        y_w;

    // stage 0: squares and zero detect
    logic                          r_v0;
    logic [SQ_W-1:0]               r_xx;
    logic [SQ_W-1:0]               r_yy;
    logic signed [SAMPLE_BITS-1:0] r_z0;
    logic                          r_zero0;

    // stage 1: radicand
    logic                          r_v1;
    t_sq                           r_sq;

    // sqrt cell chain
    logic sq_v [R_W+1];
    t_sq  sq_d [R_W+1];

    // quadrant fold
    logic                    r_vf;
    t_crd                    r_fold;
    logic signed [VEC_W-1:0] vr;
    logic signed [VEC_W-1:0] vz;

    // cordic cell chain
    logic crd_v [N_CRD+1];
    t_crd crd_d [N_CRD+1];

    // result and output registers
    logic signed [ACC_W-1:0] acc_c;
    logic signed [ACC_W-1:0] acc_r;
    logic [ANGLE_W-1:0]      res_angle;
    logic                    res_zero;
    logic                    take;
    logic                    moving;

    logic                    r_out_v;
    logic [ANGLE_W-1:0]      r_out_angle;
    logic                    r_out_zero;
    logic                    r_skid_v;
    logic [ANGLE_W-1:0]      r_skid_angle;
    logic                    r_skid_zero;

    // whole chain advances unless the skid word is occupied
    assign en          = !r_skid_v;
    assign i_smp.ready = en;

    assign x_w = SQ_W'(i_smp.accel_x);
    assign y_w = SQ_W'(i_smp.accel_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_vf <= 1'b0;
        end else if (en) begin
            r_v0 <= i_smp.valid;
            r_v1 <= r_v0;
            r_vf <= sq_v[R_W];
        end
        if (en) begin
            r_xx    <= unsigned'(x_w * x_w);
            r_yy    <= unsigned'(y_w * y_w);
            r_z0    <= i_smp.accel_z;
            r_zero0 <= (i_smp.accel_x == '0) && (i_smp.accel_y == '0)
                       && (i_smp.accel_z == '0);

            // radicand is (x*x + y*y) scaled by 2^32
            r_sq.rem  <= '0;
            r_sq.root <= '0;
            r_sq.v    <= {r_xx + r_yy, {(2*SQRT_FRAC){1'b0}}};
            r_sq.zero <= r_zero0;
            r_sq.z    <= r_z0;
        end
    end

    assign sq_v[0] = r_v1;
    assign sq_d[0] = r_sq;

    for (genvar g = 0; g < R_W; g++) begin : g_sqrt
        tilt_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_d     (sq_d[g]),
            .o_valid (sq_v[g+1]),
            .o_d     (sq_d[g+1])
        );
    end

    // r and z both carried with 24 fraction bits
    assign vr = VEC_W'(sq_d[R_W].root) <<< (VEC_FRAC - SQRT_FRAC);
    assign vz = {{(VEC_W-SAMPLE_BITS){sq_d[R_W].z[SAMPLE_BITS-1]}}, sq_d[R_W].z}
                <<< VEC_FRAC;

    // negative z: turn (z, r) by -90 degrees and start the angle at 90
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fold.zero <= sq_d[R_W].zero;
            if (sq_d[R_W].z[SAMPLE_BITS-1]) begin
                r_fold.vx  <= vr;
                r_fold.vy  <= -vz;
                r_fold.acc <= QUARTER_TURN;
            end else begin
                r_fold.vx  <= vz;
                r_fold.vy  <= vr;
                r_fold.acc <= '0;
            end
        end
    end

    assign crd_v[0] = r_vf;
    assign crd_d[0] = r_fold;

    for (genvar g = 0; g < N_CRD; g++) begin : g_cordic
        tilt_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_idx   (IDX_W'(g)),
            .i_valid (crd_v[g]),
            .i_d     (crd_d[g]),
            .o_valid (crd_v[g+1]),
            .o_d     (crd_d[g+1])
        );
    end

    // clamp to 0..180 degrees, round half up to 1/128 degree
    always_comb begin
        acc_c = crd_d[N_CRD].acc;
        if (acc_c[ACC_W-1]) begin
            acc_c = '0;
        end else if (acc_c > HALF_TURN) begin
            acc_c = HALF_TURN;
        end
        acc_r = acc_c + ROUND_HALF;
    end

    assign res_zero  = crd_d[N_CRD].zero;
    assign res_angle = res_zero ? '0 : acc_r[ANGLE_W+OUT_SHIFT-1:OUT_SHIFT];

    assign take   = r_out_v && o_res.ready;
    assign moving = en && crd_v[N_CRD];

    // output word plus skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (take) begin
                    r_out_angle <= r_skid_angle;
                    r_out_zero  <= r_skid_zero;
                    r_skid_v    <= 1'b0;
                end
            end else if (moving) begin
                if (!r_out_v || take) begin
                    r_out_angle <= res_angle;
                    r_out_zero  <= res_zero;
                    r_out_v     <= 1'b1;
                end else begin
                    r_skid_angle <= res_angle;
                    r_skid_zero  <= res_zero;
                    r_skid_v     <= 1'b1;
                end
            end else if (take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.incl_angle  = r_out_angle;
    assign o_res.zero_vector = r_out_zero;

    // skid word only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held with empty output register");

    // an undefined direction reports angle zero
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_zero) |-> (r_out_angle == '0))
        else $error("zero vector with nonzero angle");

    // angle never exceeds a half turn
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_angle <= ANGLE_W'(180 * 128)))
        else $error("tilt angle above 180 degrees");

    // a full skid word holds off new samples on the next cycle too unless drained
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !o_res.ready) |=> !i_smp.ready)
        else $error("input accepted while skid word still full");

endmodule
